/* hw/rtl/rfke_pkg.sv */
package rfke_pkg;

   // coordinate format, signed Q(COORD_WIDTH-COORD_FRAC_BITS-1).COORD_FRAC_BITS
   localparam int COORD_WIDTH     = 24;
   localparam int COORD_FRAC_BITS = 12;
   localparam int NUM_AXES        = 3;

   // stream payload widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((2 * NUM_AXES * COORD_WIDTH + 7) / 8) * 8;
   localparam int FIELD_W    = 17;
   localparam int RSP_DATA_W = ((FIELD_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int KSEL_W      = 2;
   localparam int SCALE_W     = 12;
   localparam int CSR_DATA_W  = SCALE_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_SELECT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_SCALE = CSR_INDEX_W'(1);
   localparam logic [SCALE_W-1:0]     SCALE_RESET        = SCALE_W'(512);

   // distance path: squared distance aligned to Q.32, root in Q.16
   localparam int ALIGN_W = 54;
   localparam int ROOT_W  = ALIGN_W / 2;

   // Q1.16 constants
   localparam int ONE_Q16  = 65536;
   localparam int HALF_Q16 = ONE_Q16 / 2;
   localparam int TWO_Q16  = 2 * ONE_Q16;

   typedef enum logic [KSEL_W-1:0] {
      KSEL_METABALLS,
      KSEL_MODIFIED,
      KSEL_QUARTIC,
      KSEL_SOFT
   } rfke_kernel_type;

   typedef struct packed {
      rfke_kernel_type            kernel_select;
      logic [SCALE_W-1:0]         distance_scale;
   } rfke_cfg_type;

endpackage

/* hw/rtl/radial_field_kernel_eval.sv */
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+-------------------------------------------
// req       | in  | req_tvalid / req_tready | point_x/y/z, center_x/y/z, Q11.12 each
// rsp       | out | rsp_tvalid / rsp_tready | field_value, unsigned Q1.16
// csr       | in  | csr_valid / csr_ready   | csr_index, csr_wdata
//
// one transaction per cycle sustained while no stall holds the pipe; the pipe has
// 3 distance stages, 27 square root stages (one root bit each), 7 kernel stages
// and the output register
// reset clears valid bits and restores kernel_select 0 and distance_scale 2.0
// a stall holds the whole pipe only while a result waits and the last kernel stage
// holds a valid item; bubbles still drain and new requests are taken meanwhile
module radial_field_kernel_eval
   import rfke_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // point_x, point_y, point_z, center_x, center_y, center_z
   input  logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // field_value, zero fill above
   output logic [RSP_DATA_W-1:0]  rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int MAG_W     = COORD_FRAC_BITS + 11;
   localparam int CMP_W     = (DIFF_W > MAG_W) ? DIFF_W : MAG_W;
   localparam int MAG_CLAMP = 1 << (COORD_FRAC_BITS + 10);
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ALIGN_SH  = 32 - 2 * COORD_FRAC_BITS;
   localparam int SHL       = (ALIGN_SH > 0) ? ALIGN_SH : 0;
   localparam int SHR       = (ALIGN_SH < 0) ? -ALIGN_SH : 0;
   localparam int REM_W     = ROOT_W + 3;

   typedef struct packed {
      logic [ALIGN_W-1:0] rad;
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
   } sr_stage_type;

   // one restoring square root step: bring down two radicand bits, decide one root bit
   function automatic sr_stage_type sr_step(input sr_stage_type s);
      sr_stage_type     o;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      rem_sh = {s.rem[REM_W-3:0], s.rad[ALIGN_W-1 -: 2]};
      trial  = REM_W'({s.root, 2'b01});
      o.rad  = s.rad << 2;
      if (rem_sh >= trial) begin
         o.rem  = rem_sh - trial;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = rem_sh;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // configuration registers
   rfke_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_select  <= KSEL_METABALLS;
         cfg_ff.distance_scale <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KERNEL_SELECT:  cfg_ff.kernel_select  <= rfke_kernel_type'(csr_wdata[KSEL_W-1:0]);
            CSR_DISTANCE_SCALE: cfg_ff.distance_scale <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // pipe advance, shared by every stage
   logic adv;
   logic k_valid;
   logic [FIELD_W-1:0] k_value;
   logic rsp_tvalid_ff;
   logic [FIELD_W-1:0] rsp_value_ff;

   assign adv        = !(rsp_tvalid_ff && !rsp_tready && k_valid);
   assign req_tready = adv;

   // stage d: clamped absolute differences per axis
   logic             d_vld_ff;
   logic [MAG_W-1:0] d_mag_ff [NUM_AXES];
   logic [MAG_W-1:0] d_mag_in [NUM_AXES];
   logic [DIFF_W-1:0] d_diff;
   logic [DIFF_W-1:0] d_abs;
   logic [COORD_WIDTH-1:0] d_pt, d_ct;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         d_pt   = req_tdata[a * COORD_WIDTH +: COORD_WIDTH];
         d_ct   = req_tdata[(a + NUM_AXES) * COORD_WIDTH +: COORD_WIDTH];
         d_diff = {d_pt[COORD_WIDTH-1], d_pt} - {d_ct[COORD_WIDTH-1], d_ct};
         d_abs  = d_diff[DIFF_W-1] ? (~d_diff + DIFF_W'(1)) : d_diff;
         d_mag_in[a] = (CMP_W'(d_abs) > CMP_W'(MAG_CLAMP)) ? MAG_W'(MAG_CLAMP)
                                                          : MAG_W'(d_abs);
      end
   end

   // stage q: per-axis squares
   logic            q_vld_ff;
   logic [SQ_W-1:0] q_sq_ff [NUM_AXES];
   logic [SQ_W-1:0] q_sq_in [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         q_sq_in[a] = SQ_W'(d_mag_ff[a]) * SQ_W'(d_mag_ff[a]);
      end
   end

   // stage s: sum of squares aligned to Q.32
   logic                 al_vld_ff;
   logic [ALIGN_W-1:0]   al_ff;
   logic [SUM_W-1:0]     al_sum;
   logic [SUM_W+SHL-1:0] al_wide;
   logic [ALIGN_W-1:0]   al_in;

   always_comb begin
      al_sum  = SUM_W'(q_sq_ff[0]) + SUM_W'(q_sq_ff[1]) + SUM_W'(q_sq_ff[2]);
      al_wide = (SUM_W + SHL)'(al_sum) << SHL;
      al_in   = ALIGN_W'(al_wide >> SHR);
   end

   // square root pipe, one root bit per stage
   logic [ROOT_W-1:0] sr_vld_ff;
   sr_stage_type      sr_ff  [ROOT_W];
   sr_stage_type      sr_src [ROOT_W];
   sr_stage_type      sr_in  [ROOT_W];

   always_comb begin
      sr_src[0].rad  = al_ff;
      sr_src[0].rem  = '0;
      sr_src[0].root = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         sr_src[k] = sr_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         sr_in[k] = sr_step(sr_src[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff  <= 1'b0;
         q_vld_ff  <= 1'b0;
         al_vld_ff <= 1'b0;
         sr_vld_ff <= '0;
      end else if (adv) begin
         d_vld_ff  <= req_tvalid;
         q_vld_ff  <= d_vld_ff;
         al_vld_ff <= q_vld_ff;
         sr_vld_ff <= {sr_vld_ff[ROOT_W-2:0], al_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            d_mag_ff[a] <= d_mag_in[a];
            q_sq_ff[a]  <= q_sq_in[a];
         end
         al_ff <= al_in;
         for (int k = 0; k < ROOT_W; k++) begin
            sr_ff[k] <= sr_in[k];
         end
      end
   end

   // kernel evaluation on the distance
   rfke_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (sr_vld_ff[ROOT_W-1]),
      .root      (sr_ff[ROOT_W-1].root),
      .out_valid (k_valid),
      .out_value (k_value)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv && k_valid) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && k_valid) begin
         rsp_value_ff <= k_value;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);

   // checks
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> d_vld_ff)
      else $error("accepted transaction did not enter the pipe");

   a_root_remainder: assert property (@(posedge clock) disable iff (reset)
      sr_vld_ff[ROOT_W-1] |->
         sr_ff[ROOT_W-1].rem <= (REM_W'(sr_ff[ROOT_W-1].root) << 1))
      else $error("square root remainder out of range");

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FIELD_W-1:0] <= FIELD_W'(ONE_Q16))
      else $error("field value above 1.0");

endmodule

/* hw/rtl/rfke_kernel.sv */
module rfke_kernel
   import rfke_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  rfke_cfg_type       cfg,
   input  logic               in_valid,
   input  logic [ROOT_W-1:0]  root,
   output logic               out_valid,
   output logic [FIELD_W-1:0] out_value
);

   localparam int KSQ_W        = 2 * FIELD_W;
   localparam int PRODM_W      = ROOT_W + SCALE_W;
   localparam int MD_SHIFT     = 7;
   localparam int R1M_W        = PRODM_W - MD_SHIFT;
   localparam int MB_W         = KSQ_W + 4;
   localparam int QT_W         = KSQ_W + 1;
   localparam int MB_INNER_MAX = ONE_Q16 / 6;
   localparam int MB_C12       = 12;
   localparam int MB_C3        = 3;
   localparam longint ONE_SQ_Q32 = 64'd1 << 32;
   localparam longint TWO_SQ_Q32 = 64'd1 << 33;
   localparam int N_W          = 25;
   localparam int NP4_W        = 21;
   localparam int SOFT_BASE    = 9 * ONE_Q16;
   localparam int SOFT_C4      = 4;
   localparam int SOFT_C17     = 17;
   localparam int SOFT_C22     = 22;
   localparam int DIV9         = 9;
   localparam int SOFT_ROUND   = (DIV9 - 1) / 2;
   localparam int RECIP_SHIFT  = NP4_W + 4;
   localparam longint RECIP9   = ((64'd1 << RECIP_SHIFT) + DIV9 - 1) / DIV9;
   localparam int RECIP_W      = $clog2(RECIP9 + 1);
   localparam int P9_W         = NP4_W + RECIP_W;

   // stage 1: flags on r, r squared, scaled radius product, one minus 2r
   logic               k1_vld_ff, k1_le64_ff, k1_le32_ff, k1_lemb_ff;
   logic [KSQ_W-1:0]   k1_sq_ff;
   logic [PRODM_W-1:0] k1_prodm_ff;
   logic [FIELD_W-1:0] k1_xmb_ff;
   logic               k1_le64_in, k1_le32_in, k1_lemb_in;
   logic [KSQ_W-1:0]   k1_sq_in;
   logic [PRODM_W-1:0] k1_prodm_in;
   logic [FIELD_W-1:0] k1_xmb_in;

   always_comb begin
      k1_le64_in  = root <= ROOT_W'(ONE_Q16);
      k1_le32_in  = root <= ROOT_W'(HALF_Q16);
      k1_lemb_in  = root <= ROOT_W'(MB_INNER_MAX);
      k1_sq_in    = KSQ_W'(root[FIELD_W-1:0]) * KSQ_W'(root[FIELD_W-1:0]);
      k1_prodm_in = PRODM_W'(root) * PRODM_W'(cfg.distance_scale);
      k1_xmb_in   = FIELD_W'((FIELD_W + 1)'(ONE_Q16) - (FIELD_W + 1)'({root[FIELD_W-2:0], 1'b0}));
   end

   // stage 2: modified radius, metaball outer square, inner terms
   logic               k2_vld_ff, k2_le64_ff, k2_le32_ff, k2_lemb_ff;
   logic               k2_mdle1_ff, k2_mdle2_ff;
   logic [FIELD_W-1:0] k2_mdop_ff, k2_mbv1_ff, k2_qt_ff, k2_r2_ff;
   logic [KSQ_W-1:0]   k2_xsq_ff;
   logic [R1M_W-1:0]   k2_r1m;
   logic [MB_W-1:0]    k2_mba;
   logic               k2_mdle1_in, k2_mdle2_in;
   logic [FIELD_W-1:0] k2_mdop_in, k2_mbv1_in, k2_qt_in, k2_r2_in;
   logic [KSQ_W-1:0]   k2_xsq_in;

   always_comb begin
      k2_r1m      = R1M_W'(k1_prodm_ff >> MD_SHIFT);
      k2_mdle1_in = k2_r1m <= R1M_W'(ONE_Q16);
      k2_mdle2_in = k2_r1m <= R1M_W'(TWO_Q16);
      k2_mdop_in  = k2_mdle1_in ? k2_r1m[FIELD_W-1:0]
                                : FIELD_W'((FIELD_W + 1)'(TWO_Q16) - k2_r1m[FIELD_W:0]);
      k2_xsq_in   = KSQ_W'(k1_xmb_ff) * KSQ_W'(k1_xmb_ff);
      k2_mba      = (MB_W'(k1_sq_ff) * MB_W'(MB_C12) + MB_W'(HALF_Q16)) >> 16;
      k2_mbv1_in  = FIELD_W'(MB_W'(ONE_Q16) - k2_mba);
      k2_qt_in    = FIELD_W'((QT_W'(ONE_SQ_Q32) + QT_W'(HALF_Q16) - QT_W'(k1_sq_ff)) >> 16);
      k2_r2_in    = FIELD_W'((QT_W'(k1_sq_ff) + QT_W'(HALF_Q16)) >> 16);
   end

   // stage 3: squares, metaball value
   logic               k3_vld_ff, k3_le64_ff, k3_mdle1_ff, k3_mdle2_ff;
   logic [KSQ_W-1:0]   k3_mdsq_ff, k3_tsq_ff, k3_r2sq_ff;
   logic [FIELD_W-1:0] k3_mbval_ff, k3_r2_ff;
   logic [FIELD_W-1:0] k3_mbv2;
   logic [FIELD_W-1:0] k3_mbval_in;
   logic [KSQ_W-1:0]   k3_mdsq_in, k3_tsq_in, k3_r2sq_in;

   always_comb begin
      k3_mdsq_in = KSQ_W'(k2_mdop_ff) * KSQ_W'(k2_mdop_ff);
      k3_tsq_in  = KSQ_W'(k2_qt_ff) * KSQ_W'(k2_qt_ff);
      k3_r2sq_in = KSQ_W'(k2_r2_ff) * KSQ_W'(k2_r2_ff);
      k3_mbv2    = FIELD_W'((MB_W'(k2_xsq_ff) * MB_W'(MB_C3) + MB_W'(ONE_Q16)) >> 17);
      if (k2_lemb_ff) begin
         k3_mbval_in = k2_mbv1_ff;
      end else if (k2_le32_ff) begin
         k3_mbval_in = k3_mbv2;
      end else begin
         k3_mbval_in = '0;
      end
   end

   // stage 4: modified and quartic values, soft r^4
   logic               k4_vld_ff, k4_le64_ff;
   logic [FIELD_W-1:0] k4_other_ff, k4_r4_ff, k4_r2_ff;
   logic [FIELD_W-1:0] k4_mdval, k4_qval;
   logic [FIELD_W-1:0] k4_other_in, k4_r4_in;

   always_comb begin
      if (k3_mdle1_ff) begin
         k4_mdval = FIELD_W'((QT_W'(TWO_SQ_Q32) + QT_W'(ONE_Q16) - QT_W'(k3_mdsq_ff)) >> 17);
      end else if (k3_mdle2_ff) begin
         k4_mdval = FIELD_W'((QT_W'(k3_mdsq_ff) + QT_W'(ONE_Q16)) >> 17);
      end else begin
         k4_mdval = '0;
      end
      k4_qval  = k3_le64_ff ? FIELD_W'((QT_W'(k3_tsq_ff) + QT_W'(HALF_Q16)) >> 16) : '0;
      k4_r4_in = FIELD_W'((QT_W'(k3_r2sq_ff) + QT_W'(HALF_Q16)) >> 16);
      case (cfg.kernel_select)
         KSEL_METABALLS: k4_other_in = k3_mbval_ff;
         KSEL_MODIFIED:  k4_other_in = k4_mdval;
         KSEL_QUARTIC:   k4_other_in = k4_qval;
         default:        k4_other_in = '0;
      endcase
   end

   // stage 5: soft r^6 product
   logic               k5_vld_ff, k5_le64_ff;
   logic [FIELD_W-1:0] k5_other_ff, k5_r4_ff, k5_r2_ff;
   logic [KSQ_W-1:0]   k5_r42_ff;
   logic [KSQ_W-1:0]   k5_r42_in;

   assign k5_r42_in = KSQ_W'(k4_r4_ff) * KSQ_W'(k4_r2_ff);

   // stage 6: soft polynomial, clamped and biased for rounding
   logic               k6_vld_ff;
   logic [FIELD_W-1:0] k6_other_ff;
   logic [NP4_W-1:0]   k6_np4_ff;
   logic [FIELD_W-1:0] k6_r6;
   logic [N_W-1:0]     k6_n;
   logic [NP4_W-1:0]   k6_np4_in;

   always_comb begin
      k6_r6 = FIELD_W'((QT_W'(k5_r42_ff) + QT_W'(HALF_Q16)) >> 16);
      k6_n  = N_W'(SOFT_BASE) - N_W'(k6_r6) * N_W'(SOFT_C4)
            + N_W'(k5_r4_ff) * N_W'(SOFT_C17) - N_W'(k5_r2_ff) * N_W'(SOFT_C22);
      if (!k5_le64_ff) begin
         k6_np4_in = '0;
      end else if (k6_n[N_W-1]) begin
         k6_np4_in = NP4_W'(SOFT_ROUND);
      end else begin
         k6_np4_in = k6_n[NP4_W-1:0] + NP4_W'(SOFT_ROUND);
      end
   end

   // stage 7: divide by nine through the reciprocal, kernel select, clamp to 1.0
   logic               k7_vld_ff;
   logic [FIELD_W-1:0] k7_other_ff;
   logic [P9_W-1:0]    k7_prod9_ff;
   logic [P9_W-1:0]    k7_prod9_in;
   logic [FIELD_W-1:0] k7_q9, k7_val;

   assign k7_prod9_in = P9_W'(k6_np4_ff) * P9_W'(RECIP9);

   always_comb begin
      k7_q9  = FIELD_W'(k7_prod9_ff >> RECIP_SHIFT);
      k7_val = (cfg.kernel_select == KSEL_SOFT) ? k7_q9 : k7_other_ff;
      out_value = (k7_val > FIELD_W'(ONE_Q16)) ? FIELD_W'(ONE_Q16) : k7_val;
   end

   assign out_valid = k7_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_vld_ff <= 1'b0;
         k2_vld_ff <= 1'b0;
         k3_vld_ff <= 1'b0;
         k4_vld_ff <= 1'b0;
         k5_vld_ff <= 1'b0;
         k6_vld_ff <= 1'b0;
         k7_vld_ff <= 1'b0;
      end else if (adv) begin
         k1_vld_ff <= in_valid;
         k2_vld_ff <= k1_vld_ff;
         k3_vld_ff <= k2_vld_ff;
         k4_vld_ff <= k3_vld_ff;
         k5_vld_ff <= k4_vld_ff;
         k6_vld_ff <= k5_vld_ff;
         k7_vld_ff <= k6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_le64_ff  <= k1_le64_in;
         k1_le32_ff  <= k1_le32_in;
         k1_lemb_ff  <= k1_lemb_in;
         k1_sq_ff    <= k1_sq_in;
         k1_prodm_ff <= k1_prodm_in;
         k1_xmb_ff   <= k1_xmb_in;

         k2_le64_ff  <= k1_le64_ff;
         k2_le32_ff  <= k1_le32_ff;
         k2_lemb_ff  <= k1_lemb_ff;
         k2_mdle1_ff <= k2_mdle1_in;
         k2_mdle2_ff <= k2_mdle2_in;
         k2_mdop_ff  <= k2_mdop_in;
         k2_mbv1_ff  <= k2_mbv1_in;
         k2_qt_ff    <= k2_qt_in;
         k2_r2_ff    <= k2_r2_in;
         k2_xsq_ff   <= k2_xsq_in;

         k3_le64_ff  <= k2_le64_ff;
         k3_mdle1_ff <= k2_mdle1_ff;
         k3_mdle2_ff <= k2_mdle2_ff;
         k3_mdsq_ff  <= k3_mdsq_in;
         k3_tsq_ff   <= k3_tsq_in;
         k3_r2sq_ff  <= k3_r2sq_in;
         k3_mbval_ff <= k3_mbval_in;
         k3_r2_ff    <= k2_r2_ff;

         k4_le64_ff  <= k3_le64_ff;
         k4_other_ff <= k4_other_in;
         k4_r4_ff    <= k4_r4_in;
         k4_r2_ff    <= k3_r2_ff;

         k5_le64_ff  <= k4_le64_ff;
         k5_other_ff <= k4_other_ff;
         k5_r4_ff    <= k4_r4_ff;
         k5_r2_ff    <= k4_r2_ff;
         k5_r42_ff   <= k5_r42_in;

         k6_other_ff <= k5_other_ff;
         k6_np4_ff   <= k6_np4_in;

         k7_other_ff <= k6_other_ff;
         k7_prod9_ff <= k7_prod9_in;
      end
   end

endmodule

/* tb/radial_field_kernel_eval_tb.sv */
`timescale 1ns / 1ps

module radial_field_kernel_eval_tb;
   import rfke_pkg::*;

   // run shape
   localparam int          NUM_PROBES  = 25;
   localparam int          NUM_PHASES  = 16;
   localparam int          PHASE_ITEMS = 120;
   localparam int          HOLD_CYCLES = 300;
   localparam int          TAIL_CYCLES = 50;
   localparam int unsigned CYCLE_LIMIT = 400000;

   // coordinate extremes
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // first register index that decodes to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNMAPPED = CSR_DISTANCE_SCALE + 1'b1;

   // one directed probe: configuration, point, center and, where obvious, the answer
   typedef struct {
      rfke_kernel_type               ksel;
      logic [SCALE_W-1:0]            scale;
      logic signed [COORD_WIDTH-1:0] px, py, pz, cx, cy, cz;
      bit                            known;
      logic [FIELD_W-1:0]            field;
   } probe_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // point_x, point_y, point_z, center_x, center_y, center_z
   logic [REQ_DATA_W-1:0]  req_tdata = '0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // field_value, zero fill above
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the block's registers, as the predictor sees them
   rfke_cfg_type       live_cfg;
   // field values still owed by the block, oldest first
   logic [FIELD_W-1:0] pending_fields [$];
   probe_row_type      probes [NUM_PROBES];

   int                 mismatch_count = 0;
   int unsigned        cycle_count    = 0;
   bit                 steady         = 1'b0;   // no idling on either side
   bit                 hold_request   = 1'b0;   // ask the receiver for a long stall
   logic [FIELD_W-1:0] want;

   radial_field_kernel_eval dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected field value of one request under a given configuration
   function automatic logic [FIELD_W-1:0] kernel_field(input logic [REQ_DATA_W-1:0] data,
                                                       input rfke_cfg_type cfg);
      logic signed [COORD_WIDTH-1:0] here, there;
      longint                        delta, soft_sum;
      longint unsigned               mag, sum_sq, root, trial, r1, x, t, r2, r4, r6, value;
      int                            axis, b;
      sum_sq = 0;
      // exact per-axis differences, clamped at 1024.0
      for (axis = 0; axis < NUM_AXES; axis++) begin
         here  = data[axis*COORD_WIDTH +: COORD_WIDTH];
         there = data[(axis+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
         delta = longint'(here) - longint'(there);
         mag   = (delta < 0) ? -delta : delta;
         if (mag > (64'd1 << (COORD_FRAC_BITS + 10)))
            mag = 64'd1 << (COORD_FRAC_BITS + 10);
         sum_sq += mag * mag;
      end
      // squared distance to Q.32, truncating when the format has more fraction bits
      if (2 * COORD_FRAC_BITS <= 32)
         sum_sq = sum_sq << (32 - 2 * COORD_FRAC_BITS);
      else
         sum_sq = sum_sq >> (2 * COORD_FRAC_BITS - 32);
      // floor square root, one bit at a time from the top, gives r in Q.16
      root = 0;
      for (b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sum_sq)
            root = trial;
      end
      value = 0;
      case (cfg.kernel_select)
         KSEL_METABALLS: begin
            r1 = 2 * root;
            if (3 * r1 <= ONE_Q16) begin
               value = ONE_Q16 - ((3 * r1 * r1 + HALF_Q16) >> 16);
            end else if (r1 <= ONE_Q16) begin
               x     = ONE_Q16 - r1;
               value = (3 * x * x + ONE_Q16) >> 17;
            end
         end
         KSEL_MODIFIED: begin
            // Q4.8 scale times r, doubled: a shift by 7
            r1 = (root * cfg.distance_scale) >> 7;
            if (r1 <= ONE_Q16) begin
               value = ((64'd1 << 33) - r1 * r1 + ONE_Q16) >> 17;
            end else if (r1 <= TWO_Q16) begin
               x     = TWO_Q16 - r1;
               value = (x * x + ONE_Q16) >> 17;
            end
         end
         KSEL_QUARTIC: begin
            if (root <= ONE_Q16) begin
               t     = ((64'd1 << 32) - root * root + HALF_Q16) >> 16;
               value = (t * t + HALF_Q16) >> 16;
            end
         end
         default: begin
            // soft objects with the true ninths, rounded half up at the end
            if (root <= ONE_Q16) begin
               r2       = (root * root + HALF_Q16) >> 16;
               r4       = (r2 * r2 + HALF_Q16) >> 16;
               r6       = (r4 * r2 + HALF_Q16) >> 16;
               soft_sum = 9 * ONE_Q16 - 4 * longint'(r6) + 17 * longint'(r4)
                          - 22 * longint'(r2);
               if (soft_sum < 0)
                  soft_sum = 0;
               value = (soft_sum + 4) / 9;
            end
         end
      endcase
      if (value > ONE_Q16)
         value = ONE_Q16;
      return value[FIELD_W-1:0];
   endfunction

   // random point and center; most pairs land near each other so the kernels
   // see their whole support, the rest spread wider, up to the full coordinate range
   function automatic logic [REQ_DATA_W-1:0] random_pair();
      logic [REQ_DATA_W-1:0]         data;
      logic signed [COORD_WIDTH-1:0] center, offset;
      int unsigned                   kind;
      int                            axis;
      data = '0;
      kind = $urandom_range(99);
      for (axis = 0; axis < NUM_AXES; axis++) begin
         center = COORD_WIDTH'($urandom);
         if (kind < 10)
            offset = COORD_WIDTH'(int'($urandom_range(128)) - 64);
         else if (kind < 25)
            offset = COORD_WIDTH'(int'($urandom_range(1024)) - 512);
         else if (kind < 65)
            offset = COORD_WIDTH'(int'($urandom_range(6000)) - 3000);
         else if (kind < 80)
            offset = COORD_WIDTH'(int'($urandom_range(1 << 21)) - (1 << 20));
         else
            offset = COORD_WIDTH'($urandom);
         // wraps at the coordinate edges; the predictor sees the wrapped point
         data[axis*COORD_WIDTH +: COORD_WIDTH]            = center + offset;
         data[(axis+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH] = center;
      end
      return data;
   endfunction

   // offer one request; the expectation is queued at the accepting edge
   task automatic send_request(input logic [REQ_DATA_W-1:0] data, input bit known,
                               input logic [FIELD_W-1:0] typed);
      while (!steady && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_fields.push_back(known ? typed : kernel_field(data, live_cfg));
      @(negedge clock);
   endtask

   // stop offering and wait for every owed result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_fields.size() != 0)
         @(negedge clock);
   endtask

   // write both registers back to back, then optionally an unmapped index last
   task automatic apply_config(input rfke_cfg_type target, input bit with_unmapped);
      logic [CSR_INDEX_W-1:0] idx [3];
      logic [CSR_DATA_W-1:0]  val [3];
      int                     count, n;
      idx[0] = CSR_KERNEL_SELECT;
      val[0] = CSR_DATA_W'($urandom);   // bits above the select are noise
      val[0][KSEL_W-1:0] = target.kernel_select;
      idx[1] = CSR_DISTANCE_SCALE;
      val[1] = target.distance_scale;
      idx[2] = CSR_INDEX_W'($urandom_range(2 ** CSR_INDEX_W - 1, CSR_FIRST_UNMAPPED));
      val[2] = CSR_DATA_W'($urandom);
      count  = with_unmapped ? 3 : 2;
      for (n = 0; n < count; n++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[n];
         csr_wdata <= val[n];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         if (idx[n] == CSR_KERNEL_SELECT)
            live_cfg.kernel_select = rfke_kernel_type'(val[n][KSEL_W-1:0]);
         else if (idx[n] == CSR_DISTANCE_SCALE)
            live_cfg.distance_scale = val[n];
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // receiver: random back-pressure, or a long stall on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 10);
         end
      end
   end

   // result checker: each transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fields.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result transaction, field_value %0d",
                        rsp_tdata[FIELD_W-1:0]);
            mismatch_count++;
         end else begin
            want = pending_fields.pop_front();
            if (rsp_tdata[FIELD_W-1:0] !== want) begin
               if (mismatch_count < 10)
                  $display("field_value mismatch: expected %0d, got %0d",
                           want, rsp_tdata[FIELD_W-1:0]);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      rfke_cfg_type          target;
      logic [REQ_DATA_W-1:0] data;
      int                    row, phase, n;

      // directed probes: zero distance, far apart, piece and support boundaries,
      // zero and full scale, coordinate extremes
      probes = '{
         '{KSEL_METABALLS, SCALE_RESET, 0, 0, 0, 0, 0, 0, 1'b1, FIELD_W'(ONE_Q16)},
         '{KSEL_METABALLS, SCALE_RESET, COORD_MAX, COORD_MAX, COORD_MAX,
           COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 0},
         '{KSEL_METABALLS, SCALE_RESET, COORD_MIN, COORD_MIN, COORD_MIN,
           COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 0},
         '{KSEL_METABALLS, SCALE_RESET, 2048, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_METABALLS, SCALE_RESET, 1000, -700, 300, 0, 0, 0, 1'b0, 0},
         '{KSEL_METABALLS, SCALE_RESET, -5000, 0, 0, -5100, 0, 0, 1'b0, 0},
         '{KSEL_METABALLS, SCALE_RESET, 682, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_METABALLS, SCALE_RESET, -683, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_MODIFIED, SCALE_RESET, 0, 0, 0, 0, 0, 0, 1'b1, FIELD_W'(ONE_Q16)},
         '{KSEL_MODIFIED, SCALE_RESET, 1024, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_MODIFIED, SCALE_RESET, 0, 2048, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_MODIFIED, SCALE_RESET, 1500, -200, 40, 0, 0, 0, 1'b0, 0},
         '{KSEL_MODIFIED, SCALE_RESET, 0, 0, 2049, 0, 0, 0, 1'b1, 0},
         '{KSEL_MODIFIED, 12'd0, 100000, 0, 0, 0, 0, 0, 1'b1, FIELD_W'(ONE_Q16)},
         '{KSEL_MODIFIED, 12'hFFF, 50, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_MODIFIED, 12'hFFF, 0, 300, -300, 0, 0, 0, 1'b0, 0},
         '{KSEL_QUARTIC, 12'hFFF, 0, 0, 0, 0, 0, 0, 1'b1, FIELD_W'(ONE_Q16)},
         '{KSEL_QUARTIC, 12'hFFF, 4096, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_QUARTIC, 12'hFFF, 0, 0, -4097, 0, 0, 0, 1'b1, 0},
         '{KSEL_QUARTIC, 12'hFFF, 2000, -1500, 900, 0, 0, 0, 1'b0, 0},
         '{KSEL_SOFT, 12'hFFF, COORD_MAX, COORD_MAX, COORD_MAX,
           COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, FIELD_W'(ONE_Q16)},
         '{KSEL_SOFT, 12'hFFF, 4096, 0, 0, 0, 0, 0, 1'b0, 0},
         '{KSEL_SOFT, 12'hFFF, 0, 4097, 0, 0, 0, 0, 1'b1, 0},
         '{KSEL_SOFT, 12'hFFF, 1234, 2345, -3000, 0, 0, 0, 1'b0, 0},
         '{KSEL_SOFT, 12'hFFF, COORD_MIN + 1'b1, COORD_MIN, COORD_MIN,
           COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0}
      };

      live_cfg.kernel_select  = KSEL_METABALLS;
      live_cfg.distance_scale = SCALE_RESET;

      // reset held from the start, released on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: reconfigure only where a probe asks for other settings
      for (row = 0; row < NUM_PROBES; row++) begin
         if (probes[row].ksel != live_cfg.kernel_select ||
             probes[row].scale != live_cfg.distance_scale) begin
            drain_results();
            target.kernel_select  = probes[row].ksel;
            target.distance_scale = probes[row].scale;
            apply_config(target, 1'b0);
         end
         data = {probes[row].cz, probes[row].cy, probes[row].cx,
                 probes[row].pz, probes[row].py, probes[row].px};
         send_request(data, probes[row].known, probes[row].field);
      end

      // random part: every kernel under several scales, an unmapped write now and then
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         target.kernel_select = rfke_kernel_type'(phase % 4);
         case (phase / 4)
            0:       target.distance_scale = SCALE_RESET;
            1:       target.distance_scale = SCALE_W'(1);
            2:       target.distance_scale = '1;
            default: target.distance_scale = SCALE_W'($urandom_range(2 ** SCALE_W - 1, 1));
         endcase
         apply_config(target, phase % 3 == 0);
         steady = (phase == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver stall while requests keep coming: the pipe fills
            if ((phase == 3 || phase == 9) && n == 20)
               hold_request = 1'b1;
            // sender pause until the pipe has emptied
            if (phase == 6 && n == PHASE_ITEMS / 2)
               drain_results();
            send_request(random_pair(), 1'b0, '0);
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_fields.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
